// File: src/icmp_pkg.sv
// types, constants and checksum helper for the icmp echo responder
// used by every module of the block; depends on nothing else
package icmp_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OWN_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPLY_TTL   = 1'd1;

   localparam logic [7:0] TTL_RESET  = 8'd64;
   localparam logic [7:0] PROTO_ICMP = 8'd1;

   localparam logic [5:0] PROTO_OFFSET = 6'd23;
   localparam logic [5:0] PEER_OFFSET  = 6'd26;
   localparam logic [5:0] ID_OFFSET    = 6'd38;
   localparam logic [5:0] SEQ_OFFSET   = 6'd40;
   localparam logic [5:0] POS_MAX      = 6'd63;

   localparam logic [4:0] REPLY_LAST_INDEX = 5'd27;

   // fixed words of the ip header: version/ihl, total length, ttl low byte = protocol
   localparam logic [18:0] IP_FIXED_SUM = 19'h4500 + 19'h001c + 19'h0001;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       reply_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] peer_address;
      logic [15:0] echo_id;
      logic [15:0] echo_sequence;
   } echo_job_type;

   typedef struct packed {
      logic [31:0] own_address;
      logic [7:0]  reply_ttl;
   } cfg_type;

   function automatic logic [15:0] csum_fold(input logic [18:0] sum);
      logic [16:0] s1;
      logic [15:0] s2;
      s1 = {14'd0, sum[18:16]} + {1'b0, sum[15:0]};
      s2 = s1[15:0] + {15'd0, s1[16]};
      return ~s2;
   endfunction

endpackage

// File: src/icmp_parser.sv
// front part: tracks the frame offset, captures header fields and
// pushes one reply job per icmp frame; uses icmp_pkg
module icmp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  icmp_pkg::req_payload_type req_payload,
   input  logic                     queue_full,
   output logic                     push,
   output icmp_pkg::echo_job_type   push_job
);
   import icmp_pkg::*;

   logic [5:0]  pos_ff, pos_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] peer_ff, peer_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] seq_ff, seq_in;
   logic        accept;
   logic [7:0]  b;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign b         = req_payload.frame_byte;

   always_comb begin
      proto_in = proto_ff;
      peer_in  = peer_ff;
      id_in    = id_ff;
      seq_in   = seq_ff;
      if (pos_ff == 6'd0) begin
         proto_in = 8'd0;
         peer_in  = 32'd0;
         id_in    = 16'd0;
         seq_in   = 16'd0;
      end
      priority if (pos_ff == PROTO_OFFSET) begin
         proto_in = b;
      end else if (pos_ff == PEER_OFFSET) begin
         peer_in[31:24] = b;
      end else if (pos_ff == PEER_OFFSET + 6'd1) begin
         peer_in[23:16] = b;
      end else if (pos_ff == PEER_OFFSET + 6'd2) begin
         peer_in[15:8] = b;
      end else if (pos_ff == PEER_OFFSET + 6'd3) begin
         peer_in[7:0] = b;
      end else if (pos_ff == ID_OFFSET) begin
         id_in[15:8] = b;
      end else if (pos_ff == ID_OFFSET + 6'd1) begin
         id_in[7:0] = b;
      end else if (pos_ff == SEQ_OFFSET) begin
         seq_in[15:8] = b;
      end else if (pos_ff == SEQ_OFFSET + 6'd1) begin
         seq_in[7:0] = b;
      end else begin
      end

      if (req_payload.frame_last) begin
         pos_in = 6'd0;
      end else if (pos_ff == POS_MAX) begin
         pos_in = POS_MAX;
      end else begin
         pos_in = pos_ff + 6'd1;
      end
   end

   assign push                   = accept && req_payload.frame_last && (proto_in == PROTO_ICMP);
   assign push_job.peer_address  = peer_in;
   assign push_job.echo_id       = id_in;
   assign push_job.echo_sequence = seq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 6'd0;
         proto_ff <= 8'd0;
         peer_ff  <= 32'd0;
         id_ff    <= 16'd0;
         seq_ff   <= 16'd0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         proto_ff <= proto_in;
         peer_ff  <= peer_in;
         id_ff    <= id_in;
         seq_ff   <= seq_in;
      end
   end

endmodule

// File: src/icmp_queue.sv
// short job queue between the parser and the reply sequencer
// uses icmp_pkg for the job type
module icmp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  icmp_pkg::echo_job_type push_job,
   output logic                   full,
   input  logic                   pop,
   output icmp_pkg::echo_job_type pop_job,
   output logic                   empty
);
   import icmp_pkg::*;

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] DEPTH_COUNT = CNT_WIDTH'(DEPTH);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR    = PTR_WIDTH'(DEPTH - 1);

   echo_job_type         entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_WIDTH-1:0] count_ff;

   assign full    = (count_ff == DEPTH_COUNT);
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: src/icmp_tx.sv
// back part: takes a job, works out both checksums and sends the
// 28-byte reply one byte per transfer; uses icmp_pkg
module icmp_tx (
   input  logic                      clock,
   input  logic                      reset,
   input  icmp_pkg::cfg_type         cfg,
   input  logic                      queue_empty,
   input  icmp_pkg::echo_job_type    pop_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output icmp_pkg::rsp_payload_type rsp_payload
);
   import icmp_pkg::*;

   logic         active_ff;
   logic [4:0]   idx_ff;
   echo_job_type job_ff;
   logic [15:0]  ip_csum_ff, icmp_csum_ff;
   logic         out_valid_ff;
   rsp_payload_type out_ff;

   logic         advance, sending, final_byte;
   logic [18:0]  ip_sum, icmp_sum;
   logic [7:0]   byte_sel;

   assign advance    = !out_valid_ff || !rsp_stall;
   assign sending    = active_ff && advance;
   assign final_byte = (idx_ff == REPLY_LAST_INDEX);
   assign pop        = !queue_empty && (!active_ff || (sending && final_byte));

   assign ip_sum = IP_FIXED_SUM + {3'd0, cfg.reply_ttl, 8'd0}
                 + {3'd0, cfg.own_address[31:16]} + {3'd0, cfg.own_address[15:0]}
                 + {3'd0, pop_job.peer_address[31:16]} + {3'd0, pop_job.peer_address[15:0]};
   assign icmp_sum = {3'd0, pop_job.echo_id} + {3'd0, pop_job.echo_sequence};

   always_comb begin
      unique case (idx_ff)
         5'd0:    byte_sel = 8'h45;
         5'd3:    byte_sel = 8'h1c;
         5'd8:    byte_sel = cfg.reply_ttl;
         5'd9:    byte_sel = PROTO_ICMP;
         5'd10:   byte_sel = ip_csum_ff[15:8];
         5'd11:   byte_sel = ip_csum_ff[7:0];
         5'd12:   byte_sel = cfg.own_address[31:24];
         5'd13:   byte_sel = cfg.own_address[23:16];
         5'd14:   byte_sel = cfg.own_address[15:8];
         5'd15:   byte_sel = cfg.own_address[7:0];
         5'd16:   byte_sel = job_ff.peer_address[31:24];
         5'd17:   byte_sel = job_ff.peer_address[23:16];
         5'd18:   byte_sel = job_ff.peer_address[15:8];
         5'd19:   byte_sel = job_ff.peer_address[7:0];
         5'd22:   byte_sel = icmp_csum_ff[15:8];
         5'd23:   byte_sel = icmp_csum_ff[7:0];
         5'd24:   byte_sel = job_ff.echo_id[15:8];
         5'd25:   byte_sel = job_ff.echo_id[7:0];
         5'd26:   byte_sel = job_ff.echo_sequence[15:8];
         5'd27:   byte_sel = job_ff.echo_sequence[7:0];
         default: byte_sel = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff       <= pop_job;
         ip_csum_ff   <= csum_fold(ip_sum);
         icmp_csum_ff <= csum_fold(icmp_sum);
      end
      if (sending) begin
         out_ff.reply_byte <= byte_sel;
         out_ff.reply_last <= final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= active_ff;
         end
         if (pop) begin
            active_ff <= 1'b1;
            idx_ff    <= 5'd0;
         end else if (sending) begin
            if (final_byte) begin
               active_ff <= 1'b0;
               idx_ff    <= 5'd0;
            end else begin
               idx_ff <= idx_ff + 5'd1;
            end
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// File: src/icmp_echo_reply_responder_unit.sv
// icmp echo responder top level: config registers, parser, job queue, reply sequencer
// frame bytes are taken at one per cycle while the job queue is not full; a reply is queued at the last byte
// of an icmp frame and then leaves at one byte per cycle while rsp_stall is low, 28 bytes per reply
// the job queue (QUEUE_DEPTH entries) stalls the input only when full
// synchronous active-high reset clears captures, queue and sequencer; ttl resets to 64
module icmp_echo_reply_responder_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  icmp_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output icmp_pkg::rsp_payload_type              rsp_payload,
   input  logic                                   csr_write_enable,
   input  logic [icmp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [icmp_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import icmp_pkg::*;

   cfg_type      cfg_ff;
   logic         push, pop, full, empty;
   echo_job_type push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address <= 32'd0;
         cfg_ff.reply_ttl   <= TTL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS: cfg_ff.own_address <= csr_write_data;
            CSR_REPLY_TTL:   cfg_ff.reply_ttl   <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   icmp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (full),
      .push        (push),
      .push_job    (push_job)
   );

   icmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   icmp_tx u_tx (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
